// File: hdl/tmqb_pkg.sv
`default_nettype none
package tmqb_pkg;

  localparam int QUEUES      = 8;
  localparam int DEPTH       = 16;
  localparam int MSG_LEN_MAX = 1024;

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam int KEY_W    = 32;
  localparam int TYPE_W   = 63;
  localparam int LEN_W    = 11;
  localparam int PAY_W    = 32;
  localparam int HANDLE_W = 4;
  localparam int LCMP_W   = 17;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_INVALID   = 3'd4,
    ST_AGAIN     = 3'd5,
    ST_NO_MSG    = 3'd6,
    ST_MUST_WAIT = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    FN_GET    = 3'd0,
    FN_SEND   = 3'd1,
    FN_RECV   = 3'd2,
    FN_REMOVE = 3'd3,
    FN_STAT   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_LOAD  = 2'd2
  } cell_op_e;

  typedef enum logic [2:0] {
    Q_IDLE   = 3'd0,
    Q_ALLOC  = 3'd1,
    Q_WRITE  = 3'd2,
    Q_ROTATE = 3'd3,
    Q_DROP   = 3'd4,
    Q_FREE   = 3'd5
  } q_op_e;

  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [LEN_W-1:0]  len;
    logic [PAY_W-1:0]  pay;
  } entry_t;

  typedef struct packed {
    q_op_e            op;
    logic [KEY_W-1:0] key;
    logic [PW-1:0]    pos;
    entry_t           ent;
  } q_ctrl_t;

  typedef struct packed {
    logic             live;
    logic [KEY_W-1:0] key;
    logic [CW-1:0]    fill;
    entry_t           head;
  } q_stat_t;

endpackage
`default_nettype wire

// File: hdl/tmqb_entry_cell.sv
`default_nettype none
module tmqb_entry_cell (
  input  wire logic              clk_i,
  input  wire tmqb_pkg::cell_op_e op_i,
  input  wire tmqb_pkg::entry_t  nbr_i,
  input  wire tmqb_pkg::entry_t  load_i,
  output tmqb_pkg::entry_t       data_o
);
  import tmqb_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_SHIFT: data_q <= nbr_i;
      CELL_LOAD:  data_q <= load_i;
      default:    data_q <= data_q;
    endcase
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

// File: hdl/tmqb_queue.sv
`default_nettype none
module tmqb_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tmqb_pkg::q_ctrl_t ctrl_i,
  output tmqb_pkg::q_stat_t      stat_o
);
  import tmqb_pkg::*;

  logic             live_q, live_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]    fill_q, fill_d;
  entry_t           cell_data [DEPTH];
  cell_op_e         cell_op [DEPTH];

  // Entry 0 is always the oldest; a rotation walks every cell past slot 0.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      unique case (ctrl_i.op)
        Q_ROTATE: cell_op[i] = CELL_SHIFT;
        Q_DROP:   if (PW'(i) >= ctrl_i.pos) cell_op[i] = CELL_SHIFT;
        Q_WRITE:  if (CW'(i) == fill_q) cell_op[i] = CELL_LOAD;
        default:  cell_op[i] = CELL_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tmqb_entry_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[g]),
      .nbr_i  (cell_data[(g + 1) % DEPTH]),
      .load_i (ctrl_i.ent),
      .data_o (cell_data[g])
    );
  end

  always_comb begin
    live_d = live_q;
    key_d  = key_q;
    fill_d = fill_q;
    unique case (ctrl_i.op)
      Q_ALLOC: begin
        live_d = 1'b1;
        key_d  = ctrl_i.key;
        fill_d = '0;
      end
      Q_WRITE: fill_d = fill_q + CW'(1);
      Q_DROP:  fill_d = fill_q - CW'(1);
      Q_FREE: begin
        live_d = 1'b0;
        fill_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      fill_q <= '0;
    end else begin
      live_q <= live_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign stat_o.live = live_q;
  assign stat_o.key  = key_q;
  assign stat_o.fill = fill_q;
  assign stat_o.head = cell_data[0];
endmodule
`default_nettype wire

// File: hdl/typed_message_queue_bank_unit.sv
`default_nettype none
// Bank of keyed message queues. Each queue is a row of entry cells with the
// oldest word in cell 0. Get, send, remove, stat and any rejected request
// pass through the EXEC and OUT states to a result in the output register;
// a receive that passes its checks also passes through SCAN and DROP, since
// the queue row is rotated once through all DEPTH cells to find the oldest
// matching entry at cell 0 and is then closed up in the DROP state.
// A new request is taken while a finished result still waits downstream.
module typed_message_queue_bank_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // fields from bit 0: func[3], key[32], create[1], exclusive[1], no_wait[1],
  // queue_handle[8], msg_type[64], length[11], payload[32], zero fill[7]
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // fields from bit 0: status[3], new_handle[4], type_out[63],
  // copy_length[11], payload_out[32], zero fill[7]
  output logic [119:0]      m_axis_tdata
);
  import tmqb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_DROP = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]        func_q;
  logic [KEY_W-1:0]  key_q;
  logic              create_q, excl_q, nowait_q;
  logic [7:0]        handle_q;
  logic [63:0]       type_q, mag_q;
  logic [LEN_W-1:0]  len_q;
  logic [PAY_W-1:0]  pay_q;

  logic [PW-1:0]     cnt_q;
  logic              found_q;
  logic [PW-1:0]     pos_q;
  entry_t            hit_q;

  logic [2:0]          st_q;
  logic [HANDLE_W-1:0] nh_q;
  logic [TYPE_W-1:0]   rtyp_q;
  logic [LEN_W-1:0]    rlen_q;
  logic [PAY_W-1:0]    rpay_q;

  logic                out_v_q;
  logic [2:0]          o_st_q;
  logic [HANDLE_W-1:0] o_nh_q;
  logic [TYPE_W-1:0]   o_typ_q;
  logic [LEN_W-1:0]    o_len_q;
  logic [PAY_W-1:0]    o_pay_q;

  q_ctrl_t ctrl [QUEUES];
  q_stat_t qs   [QUEUES];

  logic              in_acc;
  logic [QW-1:0]     qidx;
  logic              hbad;
  q_stat_t           sel;
  logic              hit_any, free_any;
  logic [QW-1:0]     hit_idx, free_idx;
  logic [2:0]        ex_st;
  logic [HANDLE_W-1:0] ex_nh;
  logic              ex_scan;
  q_op_e             op_c;
  logic [QW-1:0]     tgt_c;
  logic              match;
  logic              out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !out_v_q || m_axis_tready;

  assign qidx = QW'(handle_q - 8'd1);
  assign hbad = (handle_q == 8'd0) || (handle_q > 8'(QUEUES));
  assign sel  = qs[qidx];

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = QUEUES - 1; i >= 0; i--) begin
      if (qs[i].live && qs[i].key == key_q) begin
        hit_any = 1'b1;
        hit_idx = QW'(i);
      end
      if (!qs[i].live) begin
        free_any = 1'b1;
        free_idx = QW'(i);
      end
    end
  end

  // Decision for every request other than the receive scan.
  always_comb begin
    ex_st   = ST_INVALID;
    ex_nh   = '0;
    ex_scan = 1'b0;
    op_c    = Q_IDLE;
    tgt_c   = qidx;
    if (func_q == FN_GET) begin
      if (key_q != '0 && hit_any) begin
        if (create_q && excl_q) begin
          ex_st = ST_EXISTS;
        end else begin
          ex_st = ST_OK;
          ex_nh = HANDLE_W'(7'(hit_idx) + 7'd1);
        end
      end else if (key_q != '0 && !create_q) begin
        ex_st = ST_NOT_FOUND;
      end else if (free_any) begin
        ex_st = ST_OK;
        ex_nh = HANDLE_W'(7'(free_idx) + 7'd1);
        op_c  = Q_ALLOC;
        tgt_c = free_idx;
      end else begin
        ex_st = ST_NO_SPACE;
      end
    end else if (func_q > FN_STAT || hbad) begin
      ex_st = ST_INVALID;
    end else if ((func_q == FN_SEND || func_q == FN_RECV) &&
                 (LCMP_W'(len_q) > LCMP_W'(MSG_LEN_MAX))) begin
      ex_st = ST_INVALID;
    end else if (func_q == FN_SEND) begin
      if (type_q == '0 || type_q[63] || !sel.live) begin
        ex_st = ST_INVALID;
      end else if (sel.fill >= CW'(DEPTH)) begin
        ex_st = nowait_q ? ST_AGAIN : ST_MUST_WAIT;
      end else begin
        ex_st = ST_OK;
        op_c  = Q_WRITE;
      end
    end else if (func_q == FN_RECV) begin
      if (!sel.live) begin
        ex_st = ST_INVALID;
      end else begin
        ex_scan = 1'b1;
      end
    end else begin
      if (!sel.live) begin
        ex_st = ST_INVALID;
      end else begin
        ex_st = ST_OK;
        if (func_q == FN_REMOVE) op_c = Q_FREE;
      end
    end
  end

  always_comb begin
    if (type_q == '0) begin
      match = 1'b1;
    end else if (!type_q[63]) begin
      match = ({1'b0, sel.head.typ} == type_q);
    end else begin
      match = ({1'b0, sel.head.typ} <= mag_q);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUES; i++) begin
      ctrl[i].op      = Q_IDLE;
      ctrl[i].key     = key_q;
      ctrl[i].pos     = pos_q;
      ctrl[i].ent.typ = type_q[TYPE_W-1:0];
      ctrl[i].ent.len = len_q;
      ctrl[i].ent.pay = pay_q;
    end
    unique case (state_q)
      S_EXEC: ctrl[tgt_c].op = op_c;
      S_SCAN: ctrl[qidx].op  = Q_ROTATE;
      S_DROP: if (found_q) ctrl[qidx].op = Q_DROP;
      default: ;
    endcase
  end

  for (genvar g = 0; g < QUEUES; g++) begin : g_queue
    tmqb_queue u_queue (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .stat_o (qs[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: state_d = ex_scan ? S_SCAN : S_OUT;
      S_SCAN: if (cnt_q == PW'(DEPTH - 1)) state_d = S_DROP;
      S_DROP: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        cnt_q <= cnt_q + PW'(1);
        if (!found_q && CW'(cnt_q) < sel.fill && match) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q   <= s_axis_tdata[2:0];
      key_q    <= s_axis_tdata[34:3];
      create_q <= s_axis_tdata[35];
      excl_q   <= s_axis_tdata[36];
      nowait_q <= s_axis_tdata[37];
      handle_q <= s_axis_tdata[45:38];
      type_q   <= s_axis_tdata[109:46];
      len_q    <= s_axis_tdata[120:110];
      pay_q    <= s_axis_tdata[152:121];
    end
    if (state_q == S_EXEC) begin
      mag_q  <= 64'd0 - type_q;
      st_q   <= ex_st;
      nh_q   <= ex_nh;
      rtyp_q <= '0;
      rlen_q <= '0;
      rpay_q <= '0;
    end
    if (state_q == S_SCAN && !found_q && CW'(cnt_q) < sel.fill && match) begin
      pos_q <= cnt_q;
      hit_q <= sel.head;
    end
    if (state_q == S_DROP) begin
      if (found_q) begin
        st_q   <= ST_OK;
        rtyp_q <= hit_q.typ;
        rlen_q <= (hit_q.len < len_q) ? hit_q.len : len_q;
        rpay_q <= hit_q.pay;
      end else begin
        st_q <= nowait_q ? ST_NO_MSG : ST_MUST_WAIT;
      end
    end
    if (state_q == S_OUT && out_free) begin
      o_st_q  <= st_q;
      o_nh_q  <= nh_q;
      o_typ_q <= rtyp_q;
      o_len_q <= rlen_q;
      o_pay_q <= rpay_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, o_pay_q, o_len_q, o_typ_q, o_nh_q, o_st_q};

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready) else $error("request taken while busy");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (sel.fill <= CW'(DEPTH)))
    else $error("queue fill count above depth");
  a_result_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> m_axis_tvalid)
    else $error("result word lost");
`endif
endmodule
`default_nettype wire

// File: sim/testbench.sv
module testbench;
  import tmqb_pkg::*;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic        create;
    logic        excl;
    logic        no_wait;
    logic [7:0]  handle;
    logic [63:0] mtype;
    logic [10:0] len;
    logic [31:0] pay;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  handle;
    logic [62:0] mtype;
    logic [10:0] copy_len;
    logic [31:0] pay;
  } reply_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;

  typed_message_queue_bank_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Shadow of the queue bank. Each queue is kept as a plain list, oldest first.
  logic        bank_live [QUEUES];
  logic [31:0] bank_key  [QUEUES];
  entry_t      bank_msgs [QUEUES][$];

  request_t pending_req[$];
  reply_t   awaited_reply[$];
  int       errors = 0;
  bit       calm = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;

  function automatic bit type_hit(logic [62:0] stored, logic [63:0] filt);
    logic [63:0] mag;
    if (filt == 0) return 1;
    if (!filt[63]) return {1'b0, stored} == filt;
    mag = -filt;
    return {1'b0, stored} <= mag;
  endfunction

  function automatic reply_t queue_bank_apply(request_t r);
    reply_t o;
    int q;
    int hit;
    entry_t e;
    o = '0;
    o.status = ST_OK;
    if (r.func == FN_GET) begin
      if (r.key != 0) begin
        for (q = 0; q < QUEUES; q++)
          if (bank_live[q] && bank_key[q] == r.key) begin
            if (r.create && r.excl) o.status = ST_EXISTS;
            else o.handle = 4'(q + 1);
            return o;
          end
        if (!r.create) begin
          o.status = ST_NOT_FOUND;
          return o;
        end
      end
      for (q = 0; q < QUEUES; q++)
        if (!bank_live[q]) begin
          bank_live[q] = 1;
          bank_key[q] = r.key;
          bank_msgs[q].delete();
          o.handle = 4'(q + 1);
          return o;
        end
      o.status = ST_NO_SPACE;
      return o;
    end
    if (r.func > FN_STAT || r.handle == 0 || r.handle > QUEUES) begin
      o.status = ST_INVALID;
      return o;
    end
    q = r.handle - 1;
    if ((r.func == FN_SEND || r.func == FN_RECV) && r.len > MSG_LEN_MAX) begin
      o.status = ST_INVALID;
      return o;
    end
    if (r.func == FN_SEND) begin
      if (r.mtype == 0 || r.mtype[63] || !bank_live[q]) o.status = ST_INVALID;
      else if (bank_msgs[q].size() >= DEPTH)
        o.status = r.no_wait ? ST_AGAIN : ST_MUST_WAIT;
      else begin
        e.typ = r.mtype[62:0];
        e.len = r.len;
        e.pay = r.pay;
        bank_msgs[q].push_back(e);
      end
      return o;
    end
    if (!bank_live[q]) begin
      o.status = ST_INVALID;
      return o;
    end
    if (r.func == FN_RECV) begin
      hit = -1;
      for (int i = 0; i < bank_msgs[q].size(); i++)
        if (hit < 0 && type_hit(bank_msgs[q][i].typ, r.mtype)) hit = i;
      if (hit < 0) begin
        o.status = r.no_wait ? ST_NO_MSG : ST_MUST_WAIT;
        return o;
      end
      e = bank_msgs[q][hit];
      bank_msgs[q].delete(hit);
      o.mtype = e.typ;
      o.copy_len = (e.len < r.len) ? e.len : r.len;
      o.pay = e.pay;
      return o;
    end
    if (r.func == FN_REMOVE) begin
      bank_live[q] = 0;
      bank_msgs[q].delete();
    end
    return o;
  endfunction

  function automatic logic [159:0] pack_req(request_t r);
    return {7'd0, r.pay, r.len, r.mtype, r.handle, r.no_wait, r.excl, r.create,
            r.key, r.func};
  endfunction

  function automatic request_t mk_req(logic [2:0] f, logic [31:0] k, bit c, bit x,
                                      bit nw, logic [7:0] h, logic [63:0] t,
                                      logic [10:0] l, logic [31:0] p);
    request_t r;
    r.func = f; r.key = k; r.create = c; r.excl = x; r.no_wait = nw;
    r.handle = h; r.mtype = t; r.len = l; r.pay = p;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // A random type that stays small most of the time so filters find matches.
  function automatic logic [63:0] pick_type();
    case ($urandom_range(0, 5))
      0: return rnd64();
      1: return rnd64() >> 1;
      2: return 64'd0 - 64'($urandom_range(0, 6));
      default: return 64'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [10:0] pick_len();
    case ($urandom_range(0, 7))
      0: return 11'($urandom_range(MSG_LEN_MAX + 1, 2047));
      1: return 11'(MSG_LEN_MAX);
      2: return 0;
      default: return 11'($urandom_range(0, MSG_LEN_MAX));
    endcase
  endfunction

  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = mk_req(FN_GET, $urandom_range(0, 5), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               8'($urandom_range(1, QUEUES)), pick_type(), pick_len(), $urandom);
    if ($urandom_range(0, 9) == 0) r.key = $urandom;
    if ($urandom_range(0, 19) == 0) r.handle = 8'($urandom_range(0, 255));
    if (pick < 12) r.func = FN_GET;
    else if (pick < 50) r.func = FN_SEND;
    else if (pick < 85) r.func = FN_RECV;
    else if (pick < 90) r.func = FN_REMOVE;
    else if (pick < 95) r.func = FN_STAT;
    else r.func = 3'($urandom_range(5, 7));
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
  end

  initial begin
    int i;
    // Directed part: invalid calls on an empty bank, then each path once.
    pending_req.push_back(mk_req(FN_STAT, 0, 0, 0, 0, 1, 0, 0, 0));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 0, 1, 0, 0));
    pending_req.push_back(mk_req(3'd7, 0, 0, 0, 0, 255, 0, 0, 0));
    pending_req.push_back(mk_req(FN_GET, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
    pending_req.push_back(mk_req(FN_GET, 32'h8000_0000, 1, 1, 0, 0, 0, 0, 0));
    pending_req.push_back(mk_req(FN_GET, 32'h8000_0000, 1, 1, 0, 0, 0, 0, 0));
    pending_req.push_back(mk_req(FN_GET, 32'h8000_0000, 0, 1, 0, 0, 0, 0, 0));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF,
                                 11'(MSG_LEN_MAX), 32'hFFFF_FFFF));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 1, 3, 2047, 5));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0000, 4, 5));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 1, 2, 7, 9));
    pending_req.push_back(mk_req(FN_RECV, 0, 0, 0, 1, 1, 1, 10, 0));
    pending_req.push_back(mk_req(FN_RECV, 0, 0, 0, 0, 1, -2, 3, 0));
    pending_req.push_back(mk_req(FN_RECV, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0000, 2047, 0));
    pending_req.push_back(mk_req(FN_RECV, 0, 0, 0, 1, 1, 0, 0, 0));
    pending_req.push_back(mk_req(FN_RECV, 0, 0, 0, 0, 1, 0, 0, 0));
    for (i = 0; i < DEPTH + 1; i++)
      pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, i == DEPTH, 1, 64'(i + 1),
                                   11'(i), 32'(i)));
    pending_req.push_back(mk_req(FN_SEND, 0, 0, 0, 0, 1, 5, 1, 1));
    for (i = 0; i < QUEUES + 1; i++)
      pending_req.push_back(mk_req(FN_GET, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_req.push_back(mk_req(FN_REMOVE, 0, 0, 0, 0, 1, 0, 0, 0));
    pending_req.push_back(mk_req(FN_STAT, 0, 0, 0, 0, 2, 0, 0, 0));
    wait (rst_ni);
    // The sender holds back here until every result of the directed part is in.
    wait (pending_req.size() == 0 && awaited_reply.size() == 0);
    @(posedge clk_i);
    for (i = 0; i < 600; i++) begin
      pending_req.push_back(random_req());
      if (i == 450) begin
        wait (pending_req.size() == 0);
        calm = 1;
      end
    end
    wait (pending_req.size() == 0 && awaited_reply.size() == 0);
    repeat (DEPTH + 10) @(posedge clk_i);
    if (errors == 0) $display("PASS typed_message_queue_bank_unit");
    else $display("FAIL typed_message_queue_bank_unit");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL typed_message_queue_bank_unit");
    $finish;
  end

  // Driver: the prediction is made when the word is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      tx_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_reply.push_back(queue_bank_apply(pending_req.pop_front()));
      // A word on the bus stays put until it is accepted.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 0;
        end else if (pending_req.size() == 0) begin
          s_axis_tvalid <= 0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          tx_gap <= $urandom_range(1, 12) - 1;
          s_axis_tvalid <= 0;
        end else begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= pack_req(pending_req[0]);
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      rx_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[69:7],
               m_axis_tdata[80:70], m_axis_tdata[112:81]};
        if (awaited_reply.size() == 0) begin
          $display("%0t unexpected word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = awaited_reply.pop_front();
          if (got !== want) begin
            $display("%0t mismatch expected st=%0d h=%0d t=%h cl=%0d p=%h", $time,
                     want.status, want.handle, want.mtype, want.copy_len, want.pay);
            $display("%0t            actual st=%0d h=%0d t=%h cl=%0d p=%h", $time,
                     got.status, got.handle, got.mtype, got.copy_len, got.pay);
            errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(1, 12) - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

endmodule
